// File: design/srsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srsm_pkg;

    // Token store size and derived widths
    localparam int MAX_TOKENS = 64;
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);

    typedef logic [CNT_W-1:0] count_t;

    // Request codes carried on req_type
    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_PATTERN = 2'd1,
        REQ_TEXT    = 2'd2,
        REQ_END     = 2'd3
    } req_t;

    // Token kinds
    typedef enum logic [1:0] {
        KIND_LIT    = 2'd0,
        KIND_DOT    = 2'd1,
        KIND_DOLLAR = 2'd2,
        KIND_ESC    = 2'd3
    } kind_t;

    // Pattern metacharacters
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_CARET     = 8'h5E;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic       text_step;
        logic       text_clear;
        logic       started;
        logic [7:0] data;
    } cell_ctl_t;

    // Signals handed from one cell to the next
    typedef struct packed {
        logic close_e;  // star closure before the byte
        logic step;     // unstarred token consumed the byte
        logic close_f;  // star closure after the byte
    } link_t;

    // Token store write strobes from the compiler
    typedef struct packed {
        logic  push;
        logic  star;
        kind_t kind;
    } wr_t;

    // Compiled pattern status
    typedef struct packed {
        count_t total;
        logic   anchored;
        logic   esc_pending;
        logic   overflow;
        logic   end_anchor;
    } pat_t;

endpackage

`default_nettype wire

// File: design/srsm_compiler.sv
`timescale 1ns / 1ps
`default_nettype none

module srsm_compiler
    import srsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pat_clear,
    input  wire logic       pat_go,
    input  wire logic [7:0] data,
    output pat_t            pat,
    output wr_t             wr
);

    count_t total_reg, total_next;
    logic   anchored_reg, anchored_next;
    logic   begun_reg, begun_next;
    logic   esc_reg, esc_next;
    logic   ovf_reg, ovf_next;
    kind_t  last_kind_reg, last_kind_next;
    logic   last_star_reg, last_star_next;
    logic   want_push;
    kind_t  push_kind;

    // Pattern byte decode
    always_comb
    begin
        total_next     = total_reg;
        anchored_next  = anchored_reg;
        begun_next     = begun_reg;
        esc_next       = esc_reg;
        ovf_next       = ovf_reg;
        last_kind_next = last_kind_reg;
        last_star_next = last_star_reg;
        want_push      = 1'b0;
        push_kind      = KIND_LIT;
        wr             = '{push: 1'b0, star: 1'b0, kind: KIND_LIT};

        if (pat_clear)
        begin
            total_next     = '0;
            anchored_next  = 1'b0;
            begun_next     = 1'b0;
            esc_next       = 1'b0;
            ovf_next       = 1'b0;
            last_kind_next = KIND_LIT;
            last_star_next = 1'b0;
        end
        else if (pat_go && !ovf_reg)
        begin
            begun_next = 1'b1;
            if (!begun_reg && data == CH_CARET)
            begin
                anchored_next = 1'b1;
            end
            else if (esc_reg)
            begin
                esc_next  = 1'b0;
                want_push = 1'b1;
                push_kind = KIND_ESC;
            end
            else if (data == CH_BACKSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (data == CH_STAR && total_reg != '0 && !last_star_reg &&
                     last_kind_reg != KIND_ESC)
            begin
                wr.star        = 1'b1;
                last_star_next = 1'b1;
            end
            else
            begin
                want_push = 1'b1;
                case (data)
                    CH_DOT:    push_kind = KIND_DOT;
                    CH_DOLLAR: push_kind = KIND_DOLLAR;
                    default:   push_kind = KIND_LIT;
                endcase
            end
        end

        // New token, or overflow when the store is full
        if (want_push)
        begin
            if (total_reg == count_t'(MAX_TOKENS))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                wr.push        = 1'b1;
                wr.kind        = push_kind;
                total_next     = total_reg + count_t'(1);
                last_kind_next = push_kind;
                last_star_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            anchored_reg  <= 1'b0;
            begun_reg     <= 1'b0;
            esc_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            last_kind_reg <= KIND_LIT;
            last_star_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            anchored_reg  <= anchored_next;
            begun_reg     <= begun_next;
            esc_reg       <= esc_next;
            ovf_reg       <= ovf_next;
            last_kind_reg <= last_kind_next;
            last_star_reg <= last_star_next;
        end
    end

    // A final unstarred dollar anchors the end
    assign pat.total       = total_reg;
    assign pat.anchored    = anchored_reg;
    assign pat.esc_pending = esc_reg;
    assign pat.overflow    = ovf_reg;
    assign pat.end_anchor  = (total_reg != '0) && (last_kind_reg == KIND_DOLLAR) &&
                             !last_star_reg;

endmodule

`default_nettype wire

// File: design/srsm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module srsm_cell
    import srsm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      wr_en,
    input  wire logic      star_en,
    input  wire kind_t     wr_kind,
    input  wire logic      live,
    input  wire logic      at_len,
    input  wire link_t     link_in,
    output link_t          link_out,
    output logic           pre_hit,
    output logic           post_hit
);

    logic [7:0] tok_byte_reg;
    kind_t      tok_kind_reg;
    logic       tok_star_reg;
    logic       act_reg, act_next;
    logic       e_act;
    logic       tok_hit;
    logic       h_act;
    logic       f_act;

    // Position active after entry and star closure
    assign e_act = (ctl.started & act_reg) | link_in.close_e;

    // Token consumes the byte
    assign tok_hit = (tok_kind_reg == KIND_DOT) || (tok_byte_reg == ctl.data);
    assign h_act   = e_act & live & tok_hit;

    // Position active after the byte and closure
    assign f_act = (h_act & tok_star_reg) | link_in.step | link_in.close_f;

    assign link_out.close_e = e_act & tok_star_reg & live;
    assign link_out.step    = h_act & ~tok_star_reg;
    assign link_out.close_f = f_act & tok_star_reg & live;

    assign pre_hit  = e_act & at_len;
    assign post_hit = f_act & at_len;

    always_comb
    begin
        act_next = act_reg;
        if (ctl.text_clear)
        begin
            act_next = 1'b0;
        end
        else if (ctl.text_step)
        begin
            act_next = f_act;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

    // Token storage, written by the compiler
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tok_byte_reg <= ctl.data;
            tok_kind_reg <= wr_kind;
            tok_star_reg <= 1'b0;
        end
        else if (star_en)
        begin
            tok_star_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: design/simple_regex_stream_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Result: rsp_valid rises in the cycle after the end-of-text transfer.
// Throughput: one item per cycle, except that an end item waits on a stalled result;
// a text byte ripples through the row of token cells and updates every active bit.
// Reset: rst_n clears pattern, text and result-valid state asynchronously; token
// contents stay undefined until written and only entries below the count are used.

module simple_regex_stream_matcher
    import srsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] data_byte,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output logic            match_found,
    output logic            pattern_too_long
);

    logic      req_accept;
    logic      go_clear, go_pattern, go_text, go_end;
    pat_t      pat;
    wr_t       wr;
    count_t    len;
    cell_ctl_t ctl;
    link_t     link [0:MAX_TOKENS];
    logic [MAX_TOKENS:0] pre_vec;
    logic [MAX_TOKENS:0] post_vec;
    logic      pre_any, post_any;
    logic      end_pre, end_post;
    logic      hit;

    logic      started_reg, started_next;
    logic      sticky_reg, sticky_next;
    logic      act_end_reg, act_end_next;
    logic      rsp_valid_reg, rsp_valid_next;
    logic      match_reg;
    logic      too_long_reg;

    // Input handshake: only an end item waits on a stalled result
    assign req_stall  = rsp_valid_reg && rsp_stall && (req_type == REQ_END);
    assign req_accept = req_valid && !req_stall;
    assign go_clear   = req_accept && (req_type == REQ_CLEAR);
    assign go_pattern = req_accept && (req_type == REQ_PATTERN);
    assign go_text    = req_accept && (req_type == REQ_TEXT);
    assign go_end     = req_accept && (req_type == REQ_END);

    srsm_compiler u_compiler (
        .clk       (clk),
        .rst_n     (rst_n),
        .pat_clear (go_clear),
        .pat_go    (go_pattern),
        .data      (data_byte),
        .pat       (pat),
        .wr        (wr)
    );

    // Consuming tokens exclude the end anchor
    assign len = pat.total - count_t'(pat.end_anchor);

    assign ctl.text_step  = go_text;
    assign ctl.text_clear = go_clear || go_pattern || go_end;
    assign ctl.started    = started_reg;
    assign ctl.data       = data_byte;

    // Seed of position zero: start of text, or any position when unanchored
    assign link[0].close_e = ~started_reg | ~pat.anchored;
    assign link[0].step    = 1'b0;
    assign link[0].close_f = 1'b0;

    // Row of token cells
    for (genvar g = 0; g < MAX_TOKENS; g++)
    begin : g_cell
        srsm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .wr_en    (wr.push && (pat.total == count_t'(g))),
            .star_en  (wr.star && (pat.total == count_t'(g + 1))),
            .wr_kind  (wr.kind),
            .live     (count_t'(g) < len),
            .at_len   (len == count_t'(g)),
            .link_in  (link[g]),
            .link_out (link[g + 1]),
            .pre_hit  (pre_vec[g]),
            .post_hit (post_vec[g])
        );
    end

    // Position past the last token
    assign end_pre  = (started_reg & act_end_reg) | link[MAX_TOKENS].close_e;
    assign end_post = link[MAX_TOKENS].step | link[MAX_TOKENS].close_f;
    assign pre_vec[MAX_TOKENS]  = end_pre & (len == count_t'(MAX_TOKENS));
    assign post_vec[MAX_TOKENS] = end_post & (len == count_t'(MAX_TOKENS));

    assign pre_any  = |pre_vec;
    assign post_any = |post_vec;

    // End-of-text verdict
    always_comb
    begin
        if (pat.overflow || pat.esc_pending)
        begin
            hit = 1'b0;
        end
        else if (pat.end_anchor)
        begin
            hit = pre_any;
        end
        else
        begin
            hit = sticky_reg || pre_any;
        end
    end

    // Text state and result valid
    always_comb
    begin
        started_next   = started_reg;
        sticky_next    = sticky_reg;
        act_end_next   = act_end_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (ctl.text_clear)
        begin
            started_next = 1'b0;
            sticky_next  = 1'b0;
            act_end_next = 1'b0;
        end
        else if (go_text)
        begin
            started_next = 1'b1;
            act_end_next = end_post;
            if (!pat.end_anchor && (pre_any || post_any))
            begin
                sticky_next = 1'b1;
            end
        end

        if (go_end)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            sticky_reg    <= 1'b0;
            act_end_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            sticky_reg    <= sticky_next;
            act_end_reg   <= act_end_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (go_end)
        begin
            match_reg    <= hit;
            too_long_reg <= pat.overflow;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign match_found      = match_reg;
    assign pattern_too_long = too_long_reg;

    // Overflowed pattern never reports a match
    a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && pattern_too_long |-> !match_found)
        else $error("match reported for overflowed pattern");

    // End-of-text transfer yields a result next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        go_end |=> rsp_valid_reg)
        else $error("no result after end of text");

    // Text state is cleared after end of text
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go_end |=> (!started_reg && !sticky_reg && !act_end_reg))
        else $error("text state not cleared");

    // Token count never exceeds the store
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        pat.total <= count_t'(MAX_TOKENS))
        else $error("token count beyond store");

    // End anchor needs at least one token
    a_anchor_total: assert property (@(posedge clk) disable iff (!rst_n)
        pat.end_anchor |-> (pat.total != '0))
        else $error("end anchor with empty store");

endmodule

`default_nettype wire

// File: sim/simple_regex_stream_matcher_test.sv
`timescale 1ns / 1ps

module simple_regex_stream_matcher_test;

    import srsm_pkg::*;

    localparam int DIR_COUNT   = 27;
    localparam int ITEM_TARGET = DIR_COUNT + 1050;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic match;
        logic too_long;
    } verdict_t;

    typedef struct packed {
        req_t       kind;
        logic [7:0] data;
        logic       fixed;
        logic       want_match;
        logic       want_long;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_t       req_type;
    logic [7:0] data_byte;
    logic       rsp_valid;
    logic       rsp_stall;
    logic       match_found;
    logic       pattern_too_long;

    // Mirror of the compiled pattern and the text NFA
    logic [7:0]          tok_byte [MAX_TOKENS];
    kind_t               tok_kind [MAX_TOKENS];
    logic                tok_star [MAX_TOKENS];
    int unsigned         tok_count;
    logic                anchored;
    logic                begun;
    logic                esc_pend;
    logic                ovf;
    logic [MAX_TOKENS:0] live_pos;
    logic                sticky;
    logic                txt_started;

    verdict_t  verdict_q [$];
    verdict_t  want;
    verdict_t  pred_verdict;
    bit        pred_has;
    stim_row_t dir_rows [DIR_COUNT];

    bit  row_fixed;
    bit  row_match;
    bit  row_long;
    bit  idle_on;
    int  reqs_sent;
    int  stall_left;
    int  err_count;
    int  cycle_count;

    simple_regex_stream_matcher DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req_type         (req_type),
        .data_byte        (data_byte),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .match_found      (match_found),
        .pattern_too_long (pattern_too_long)
    );

    always #2 clk = ~clk;

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic flag_error(string what);
        err_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic void drop_text();
        live_pos    = '0;
        sticky      = 1'b0;
        txt_started = 1'b0;
    endfunction

    function automatic void drop_pattern();
        tok_count = 0;
        anchored  = 1'b0;
        begun     = 1'b0;
        esc_pend  = 1'b0;
        ovf       = 1'b0;
        drop_text();
    endfunction

    function automatic void add_token(logic [7:0] b, kind_t k);
        if (tok_count >= MAX_TOKENS)
        begin
            ovf = 1'b1;
            return;
        end
        tok_byte[tok_count] = b;
        tok_kind[tok_count] = k;
        tok_star[tok_count] = 1'b0;
        tok_count++;
    endfunction

    // Pattern compiler: caret, escape and star rules
    function automatic void compile_byte(logic [7:0] b);
        if (ovf)
            return;
        if (!begun)
        begin
            begun = 1'b1;
            if (b == CH_CARET)
            begin
                anchored = 1'b1;
                return;
            end
        end
        if (esc_pend)
        begin
            esc_pend = 1'b0;
            add_token(b, KIND_ESC);
            return;
        end
        if (b == CH_BACKSLASH)
        begin
            esc_pend = 1'b1;
            return;
        end
        if (b == CH_STAR && tok_count > 0 && !tok_star[tok_count - 1] &&
            tok_kind[tok_count - 1] != KIND_ESC)
        begin
            tok_star[tok_count - 1] = 1'b1;
            return;
        end
        if (b == CH_DOT)
            add_token(b, KIND_DOT);
        else if (b == CH_DOLLAR)
            add_token(b, KIND_DOLLAR);
        else
            add_token(b, KIND_LIT);
    endfunction

    // Starred tokens may be skipped; walk upward so chains of them close
    function automatic void star_close(int unsigned len);
        for (int k = 0; k < len; k++)
            if (live_pos[k] && tok_star[k])
                live_pos[k + 1] = 1'b1;
    endfunction

    function automatic void nfa_step(input req_t t, input logic [7:0] b,
                                     output bit has_res, output verdict_t v);
        int unsigned         len;
        bit                  ea;
        logic [MAX_TOKENS:0] nxt;
        has_res = 1'b0;
        v       = '0;
        case (t)
            REQ_CLEAR:
                drop_pattern();
            REQ_PATTERN:
            begin
                drop_text();
                compile_byte(b);
            end
            default:
            begin
                // A final unstarred dollar anchors the end and consumes nothing
                len = tok_count;
                ea  = 1'b0;
                if (len > 0 && tok_kind[len - 1] == KIND_DOLLAR && !tok_star[len - 1])
                begin
                    ea = 1'b1;
                    len--;
                end
                if (!txt_started)
                begin
                    live_pos    = '0;
                    live_pos[0] = 1'b1;
                    txt_started = 1'b1;
                end
                else if (!anchored)
                    live_pos[0] = 1'b1;
                star_close(len);
                if (t == REQ_TEXT)
                begin
                    if (!ea && live_pos[len])
                        sticky = 1'b1;
                    nxt = '0;
                    for (int k = 0; k < len; k++)
                        if (live_pos[k] && (tok_kind[k] == KIND_DOT || tok_byte[k] == b))
                        begin
                            if (tok_star[k])
                                nxt[k] = 1'b1;
                            else
                                nxt[k + 1] = 1'b1;
                        end
                    live_pos = nxt;
                    star_close(len);
                    if (!ea && live_pos[len])
                        sticky = 1'b1;
                end
                else
                begin
                    has_res = 1'b1;
                    if (ovf || esc_pend)
                        v.match = 1'b0;
                    else if (ea)
                        v.match = live_pos[len];
                    else
                        v.match = sticky || live_pos[len];
                    v.too_long = ovf;
                    drop_text();
                end
            end
        endcase
    endfunction

    // Small alphabet heavy on metacharacters, with the odd arbitrary byte
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 13))
            0, 1, 2: return "a";
            3, 4:    return "b";
            5:       return "c";
            6:       return CH_DOT;
            7:       return CH_STAR;
            8:       return CH_BACKSLASH;
            9:       return CH_DOLLAR;
            10:      return CH_CARET;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One request transfer, with an optional idle burst ahead of it
    task automatic send_req(req_t t, logic [7:0] b, bit fixed, bit fm, bit fl);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_type  <= t;
        data_byte <= b;
        row_fixed = fixed;
        row_match = fm;
        row_long  = fl;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        reqs_sent++;
    endtask

    // Predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            nfa_step(req_type, data_byte, pred_has, pred_verdict);
            if (pred_has)
            begin
                if (row_fixed)
                    verdict_q.push_back('{row_match, row_long});
                else
                    verdict_q.push_back(pred_verdict);
            end
        end
    end

    // Check every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            if (verdict_q.size() == 0)
                flag_error($sformatf("result with nothing pending: match=%b long=%b",
                                     match_found, pattern_too_long));
            else
            begin
                want = verdict_q.pop_front();
                if (match_found !== want.match)
                    flag_error($sformatf("match_found %b, want %b",
                                         match_found, want.match));
                if (pattern_too_long !== want.too_long)
                    flag_error($sformatf("pattern_too_long %b, want %b",
                                         pattern_too_long, want.too_long));
            end
        end
    end

    // Result side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    initial
    begin : stimulus
        int         plen;
        int         roll;
        int         tlen;
        logic [7:0] c;
        logic [7:0] pat [$];
        logic [7:0] txt [$];

        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_type    = REQ_CLEAR;
        data_byte   = 8'h00;
        rsp_stall   = 1'b0;
        row_fixed   = 1'b0;
        row_match   = 1'b0;
        row_long    = 1'b0;
        idle_on     = 1'b1;
        reqs_sent   = 0;
        stall_left  = 0;
        err_count   = 0;
        cycle_count = 0;
        drop_pattern();

        // Directed rows: empty pattern, stars that stay literal, escapes,
        // star after star, dollar, pattern change mid-text, lone backslash
        dir_rows = '{
            '{REQ_END,     8'h00,        1'b1, 1'b1, 1'b0},
            '{REQ_TEXT,    8'h00,        1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,    8'hFF,        1'b0, 1'b0, 1'b0},
            '{REQ_END,     8'hFF,        1'b1, 1'b1, 1'b0},
            '{REQ_PATTERN, CH_CARET,     1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_BACKSLASH, 1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,    CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,    CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,    CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_END,     8'h00,        1'b0, 1'b0, 1'b0},
            '{REQ_CLEAR,   8'hFF,        1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, "a",          1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_DOT,       1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, 8'hFF,        1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_DOLLAR,    1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,    "a",          1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,    CH_STAR,      1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,    8'hFF,        1'b0, 1'b0, 1'b0},
            '{REQ_END,     8'h00,        1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,    "b",          1'b0, 1'b0, 1'b0},
            '{REQ_PATTERN, CH_BACKSLASH, 1'b0, 1'b0, 1'b0},
            '{REQ_END,     8'h00,        1'b1, 1'b0, 1'b0}
        };

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_COUNT; r++)
            send_req(dir_rows[r].kind, dir_rows[r].data, dir_rows[r].fixed,
                     dir_rows[r].want_match, dir_rows[r].want_long);

        // Random sessions: pattern, then a few texts each closed by an end item
        while (reqs_sent < ITEM_TARGET)
        begin
            idle_on = (reqs_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            roll    = $urandom_range(0, 19);

            // Noise: any request with any byte
            if (roll == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_req(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'b0, 1'b0, 1'b0);
                continue;
            end

            // Occasionally keep appending to the previous pattern
            if (roll != 1)
            begin
                send_req(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
                pat.delete();
            end

            // Long patterns straddle the token store size
            plen = (roll == 2) ? $urandom_range(62, 70) : $urandom_range(0, 7);
            for (int k = 0; k < plen; k++)
            begin
                if (roll == 2)
                    c = ($urandom_range(0, 9) == 0) ? CH_STAR : 8'("a" + $urandom_range(0, 2));
                else
                    c = pick_char();
                pat.push_back(c);
                send_req(REQ_PATTERN, c, 1'b0, 1'b0, 1'b0);
            end

            repeat ($urandom_range(1, 4))
            begin
                txt.delete();
                if (pat.size() > 0 && $urandom_range(0, 1) == 1)
                begin
                    // Text shaped after the pattern so that matches are common
                    if ($urandom_range(0, 2) == 0)
                        txt.push_back(pick_char());
                    for (int k = 0; k < pat.size(); k++)
                    begin
                        c = pat[k];
                        if (c == CH_CARET || c == CH_DOLLAR || c == CH_BACKSLASH)
                            continue;
                        if (c == CH_STAR)
                        begin
                            if (txt.size() > 0)
                            begin
                                if ($urandom_range(0, 1) == 1)
                                    txt.push_back(txt[$]);
                                else
                                    void'(txt.pop_back());
                            end
                            continue;
                        end
                        if (c == CH_DOT)
                            c = pick_char();
                        txt.push_back(c);
                    end
                    if ($urandom_range(0, 2) == 0)
                        txt.push_back(pick_char());
                end
                else
                begin
                    tlen = $urandom_range(0, 8);
                    repeat (tlen)
                        txt.push_back(pick_char());
                end
                foreach (txt[k])
                    send_req(REQ_TEXT, txt[k], 1'b0, 1'b0, 1'b0);
                send_req(REQ_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        idle_on = 1'b0;

        // Drain, then wait on for stray results
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
design/srsm_pkg.sv
design/srsm_compiler.sv
design/srsm_cell.sv
design/simple_regex_stream_matcher.sv
sim/simple_regex_stream_matcher_test.sv
